// ===== rtl/core/ctrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrb_pkg
// Shared types and codes of the controllability matrix unit.
// ----------------------------------------------------------------------------
package ctrb_pkg;

    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] STATE_COUNT_RST = 3'd4;
    localparam logic [CFG_W-1:0] INPUT_COUNT_RST = 3'd1;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [3:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } out_t;

    typedef struct packed {
        logic       load_a;
        logic       load_b;
        logic       rd_b;
        logic       rd_term;
        logic       mul;
        logic       acc_en;
        logic       acc_first;
        logic       emit;
        logic       emit_src_b;
        logic       last;
        logic [3:0] out_col;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/ctrb_datapath.sv =====
// ----------------------------------------------------------------------------
// ctrb_datapath
// Element stores, working blocks, shared multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module ctrb_datapath #(
    parameter int MAX_STATES = 4,
    parameter int MAX_INPUTS = 4
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  ctrb_pkg::in_t                               s_data,
    input  ctrb_pkg::ctrl_cmd_t                         cmd,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] idx_r,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] idx_t,
    input  logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] idx_c,
    input  logic                                        bank,
    output ctrb_pkg::dp_sts_t                           sts,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output ctrb_pkg::out_t                              m_data
);

    localparam int RW      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int A_DEPTH = 1 << (2 * RW);
    localparam int B_DEPTH = 1 << (RW + CW);
    localparam int W_DEPTH = 1 << (1 + RW + CW);
    localparam int ACCW    = 64 + RW;

    logic signed [31:0] a_mem [A_DEPTH];
    logic signed [31:0] b_mem [B_DEPTH];
    logic signed [31:0] w_mem [W_DEPTH];

    logic signed [31:0]   a_rd_reg;
    logic signed [31:0]   b_rd_reg;
    logic signed [31:0]   w_rd_reg;
    logic signed [63:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic                 m_valid_reg;
    ctrb_pkg::out_t       m_data_reg;

    logic               a_in_range;
    logic               b_in_range;
    logic [ACCW-48:0]   acc_top;
    logic               acc_fits;
    logic signed [31:0] sat_value;
    logic signed [31:0] emit_value;

    assign a_in_range = (int'(s_data.row) < MAX_STATES) && (int'(s_data.col) < MAX_STATES);
    assign b_in_range = (int'(s_data.row) < MAX_STATES) && (int'(s_data.col) < MAX_INPUTS);

    assign acc_top  = acc_reg[ACCW-1:47];
    assign acc_fits = (&acc_top) | ~(|acc_top);

    always_comb begin
        if (acc_fits) begin
            sat_value = acc_reg[47:16];
        end else if (acc_reg[ACCW-1]) begin
            sat_value = 32'sh8000_0000;
        end else begin
            sat_value = 32'sh7FFF_FFFF;
        end
    end

    assign emit_value = cmd.emit_src_b ? b_rd_reg : sat_value;

    always_ff @(posedge aclk) begin
        if (cmd.load_a && a_in_range) begin
            a_mem[{RW'(s_data.row), RW'(s_data.col)}] <= s_data.value;
        end
        if (cmd.rd_term) begin
            a_rd_reg <= a_mem[{idx_r, idx_t}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_b && b_in_range) begin
            b_mem[{RW'(s_data.row), CW'(s_data.col)}] <= s_data.value;
        end
        if (cmd.rd_b) begin
            b_rd_reg <= b_mem[{idx_r, idx_c}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            w_mem[{bank, idx_r, idx_c}] <= emit_value;
        end
        if (cmd.rd_term) begin
            w_rd_reg <= w_mem[{~bank, idx_t, idx_c}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= a_rd_reg * w_rd_reg;
        end
        if (cmd.acc_en) begin
            acc_reg <= (cmd.acc_first ? '0 : acc_reg) + ACCW'(prod_reg);
        end
        if (cmd.emit) begin
            m_data_reg.out_row   <= 2'(idx_r);
            m_data_reg.out_col   <= cmd.out_col;
            m_data_reg.out_value <= emit_value;
            m_data_reg.last      <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

// ===== rtl/core/ctrb_controller.sv =====
// ----------------------------------------------------------------------------
// ctrb_controller
// Configuration registers and the sequencer over blocks, rows, columns, terms.
// ----------------------------------------------------------------------------
module ctrb_controller #(
    parameter int MAX_STATES = 4,
    parameter int MAX_INPUTS = 4
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic [ctrb_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [ctrb_pkg::CFG_W-1:0]                  cfg_wdata,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  ctrb_pkg::in_t                               s_data,
    input  ctrb_pkg::dp_sts_t                           sts,
    output ctrb_pkg::ctrl_cmd_t                         cmd,
    output logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] idx_r,
    output logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] idx_t,
    output logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] idx_c,
    output logic                                        bank
);

    localparam int RW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_B_RD   = 3'd1;
    localparam logic [2:0] ST_B_EMIT = 3'd2;
    localparam logic [2:0] ST_T_RD   = 3'd3;
    localparam logic [2:0] ST_T_MUL  = 3'd4;
    localparam logic [2:0] ST_T_ACC  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [ctrb_pkg::CFG_W-1:0]  sc_reg, ic_reg;
    logic [RW-1:0]               n_last_reg, n_last_next;
    logic [CW-1:0]               m_last_reg, m_last_next;
    logic [RW-1:0]               b_reg, b_next;
    logic [RW-1:0]               r_reg, r_next;
    logic [RW-1:0]               t_reg, t_next;
    logic [CW-1:0]               c_reg, c_next;
    logic [3:0]                  base_reg, base_next;
    logic [3:0]                  m_width;
    logic                        blk_zero;

    assign m_width  = 4'(m_last_reg) + 4'd1;
    assign blk_zero = (state_reg == ST_B_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg <= ctrb_pkg::STATE_COUNT_RST;
            ic_reg <= ctrb_pkg::INPUT_COUNT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == ctrb_pkg::CFG_STATE_COUNT) begin
                sc_reg <= cfg_wdata;
            end
            if (cfg_index == ctrb_pkg::CFG_INPUT_COUNT) begin
                ic_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        n_last_next = n_last_reg;
        m_last_next = m_last_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        t_next      = t_reg;
        c_next      = c_reg;
        base_next   = base_reg;
        cmd         = '0;
        cmd.out_col = base_reg + 4'(c_reg);
        cmd.last    = (b_reg == n_last_reg) && (r_reg == n_last_reg) && (c_reg == m_last_reg);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.command)
                        ctrb_pkg::CMD_LOAD_A: begin
                            cmd.load_a = 1'b1;
                        end
                        ctrb_pkg::CMD_LOAD_B: begin
                            cmd.load_b = 1'b1;
                        end
                        ctrb_pkg::CMD_START: begin
                            if (sc_reg == '0) begin
                                n_last_next = '0;
                            end else if (int'(sc_reg) > MAX_STATES) begin
                                n_last_next = RW'(MAX_STATES - 1);
                            end else begin
                                n_last_next = RW'(sc_reg - 3'd1);
                            end
                            if (ic_reg == '0) begin
                                m_last_next = '0;
                            end else if (int'(ic_reg) > MAX_INPUTS) begin
                                m_last_next = CW'(MAX_INPUTS - 1);
                            end else begin
                                m_last_next = CW'(ic_reg - 3'd1);
                            end
                            b_next     = '0;
                            r_next     = '0;
                            c_next     = '0;
                            t_next     = '0;
                            base_next  = '0;
                            state_next = ST_B_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_B_RD: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_B_EMIT;
            end
            ST_T_RD: begin
                cmd.rd_term = 1'b1;
                state_next  = ST_T_MUL;
            end
            ST_T_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_T_ACC;
            end
            ST_T_ACC: begin
                cmd.acc_en    = 1'b1;
                cmd.acc_first = (t_reg == '0);
                if (t_reg == n_last_reg) begin
                    t_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end
            ST_B_EMIT, ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_src_b = blk_zero;
                    state_next     = blk_zero ? ST_B_RD : ST_T_RD;
                    if (c_reg == m_last_reg) begin
                        c_next = '0;
                        if (r_reg == n_last_reg) begin
                            r_next = '0;
                            if (b_reg == n_last_reg) begin
                                state_next = ST_IDLE;
                            end else begin
                                b_next     = b_reg + 1'b1;
                                base_next  = base_reg + m_width;
                                state_next = ST_T_RD;
                            end
                        end else begin
                            r_next = r_reg + 1'b1;
                        end
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_last_reg <= n_last_next;
        m_last_reg <= m_last_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        t_reg      <= t_next;
        c_reg      <= c_next;
        base_reg   <= base_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign idx_r   = r_reg;
    assign idx_t   = t_reg;
    assign idx_c   = c_reg;
    assign bank    = b_reg[0];

`ifndef NO_ASSERTIONS
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result written while output register is occupied");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && cmd.last |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after final element");

    a_emit_only_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !cmd.last |=> state_reg != ST_IDLE)
        else $error("sequencer went idle before final element");

    a_term_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_T_ACC |-> t_reg <= n_last_reg && b_reg != '0)
        else $error("term index or block index out of range");
`endif

endmodule

// ===== rtl/core/controllability_matrix_unit.sv =====
// Load transactions (write A or B element) are taken while idle; s_ready is high whenever idle.
// A start streams n*n*m results: block 0 copies each element from the B memory,
// each later element is computed through the single shared 32x32 multiply-accumulate
// (read, multiply, accumulate per term), and the sequencer waits while m_ready holds the output register.
// No new transaction is taken until the final element has been handed to the output register.
// Reset (aresetn low, synchronous) restores n=4, m=1 and idles; matrix contents are kept.
// ----------------------------------------------------------------------------
// controllability_matrix_unit
// Builds [B, AB, ..., A^(n-1)B] in signed Q16.16 and streams it element by element.
// ----------------------------------------------------------------------------
module controllability_matrix_unit #(
    parameter int MAX_STATES = 4,
    parameter int MAX_INPUTS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ctrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctrb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ctrb_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ctrb_pkg::out_t                 m_data
);

    localparam int RW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    ctrb_pkg::ctrl_cmd_t cmd;
    ctrb_pkg::dp_sts_t   sts;
    logic [RW-1:0]       idx_r;
    logic [RW-1:0]       idx_t;
    logic [CW-1:0]       idx_c;
    logic                bank;

    ctrb_controller #(
        .MAX_STATES (MAX_STATES),
        .MAX_INPUTS (MAX_INPUTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .sts       (sts),
        .cmd       (cmd),
        .idx_r     (idx_r),
        .idx_t     (idx_t),
        .idx_c     (idx_c),
        .bank      (bank)
    );

    ctrb_datapath #(
        .MAX_STATES (MAX_STATES),
        .MAX_INPUTS (MAX_INPUTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .idx_r   (idx_r),
        .idx_t   (idx_t),
        .idx_c   (idx_c),
        .bank    (bank),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
